// ----- hw/rtl/apt_pkg.sv -----
// Shared constants and codes of the affine point transform unit.
`timescale 1ns / 1ps
package apt_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int MAT_W          = 32;
    localparam int FRAC_BITS      = 16;
    localparam int CFG_ADDR_W     = 3;

    localparam logic [CFG_ADDR_W-1:0] REG_M00 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_M01 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_M10 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_M11 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_M20 = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_M21 = 3'd5;

    localparam logic signed [MAT_W-1:0] UNITY = 32'sd65536;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_SAT      = 2'd1;
    localparam logic [1:0] STATUS_SINGULAR = 2'd2;

    localparam logic FUNC_INVERSE = 1'b1;

endpackage

// ----- hw/rtl/affine_point_transform_unit.sv -----
// Top level of the pipelined 2D affine point transform unit.
`timescale 1ns / 1ps
//
// Maps integer points through a 2D affine matrix of six Q16.16 registers.
// Input stream: s_axis_tuser selects forward (0) or inverse (1); s_axis_tdata
// carries x_in and y_in. Output stream: m_axis_tdata carries x_out, y_out
// and a status code (ok, saturated, singular matrix).
// The matrix is loaded through cfg_we/cfg_addr/cfg_wdata; the user must load it
// only while no transaction is in flight, which the block does not enforce.
// Writes to unused indexes are ignored. The stages are four of multiply and
// sum, one overflow check, one restoring divider stage per quotient bit
// (COORD_BITS + 1 of them) and the rounding/output register.
// Throughput is one point per cycle while the output is not stalled; the divider stages are not shared.
// Every stage holds a valid bit and takes new data when empty or when its
// content moves on, so a stalled output only backs up the pipeline once
// all bubbles ahead of it are filled; no transaction is lost or repeated.
// Reset empties the pipeline and loads the identity matrix.
//
module affine_point_transform_unit
    import apt_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_ADDR_W-1:0]        cfg_addr,
    input  logic [MAT_W-1:0]             cfg_wdata,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    // tdata: x_in, y_in (lowest bits first)
    input  logic [((2*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // tuser: func
    input  logic                         s_axis_tuser,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    // tdata: x_out, y_out, status (lowest bits first)
    output logic [((2*COORD_BITS+9)/8)*8-1:0] m_axis_tdata
);

    localparam int CB     = COORD_BITS;
    localparam int OUT_DW = ((2*CB+9)/8)*8;
    localparam int PW     = CB + MAT_W;
    localparam int AW     = PW + 1;
    localparam int DW     = 2*MAT_W + 1;
    localparam int NW     = CB + 50;
    localparam int RW     = DW + CB + 1;
    localparam int NDV    = CB + 2;
    localparam int NS     = CB + 7;
    localparam int DV0    = 4;
    localparam logic signed [DW-1:0] D_FWD = DW'(64'd1 << FRAC_BITS);
    localparam logic [CB+1:0] LIM_POS = (CB+2)'((64'd1 << (CB-1)) - 64'd1);
    localparam logic [CB+1:0] LIM_NEG = (CB+2)'(64'd1 << (CB-1));

    // Configuration registers.
    logic signed [MAT_W-1:0] m00_reg, m01_reg, m10_reg, m11_reg, m20_reg, m21_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m00_reg <= UNITY;
            m01_reg <= '0;
            m10_reg <= '0;
            m11_reg <= UNITY;
            m20_reg <= '0;
            m21_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_M00: m00_reg <= cfg_wdata;
                REG_M01: m01_reg <= cfg_wdata;
                REG_M10: m10_reg <= cfg_wdata;
                REG_M11: m11_reg <= cfg_wdata;
                REG_M20: m20_reg <= cfg_wdata;
                REG_M21: m21_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Pipeline control: a stage loads when empty or when its content moves on.
    logic [NS-1:0] v_reg;
    logic [NS-1:0] ld;
    logic [NS-1:0] v_next;

    assign ld[NS-1] = !v_reg[NS-1] || m_axis_tready;
    generate
        for (genvar k = 0; k < NS-1; k++)
        begin : g_ld
            assign ld[k] = !v_reg[k] || ld[k+1];
        end
    endgenerate

    assign v_next = {v_reg[NS-2:0], s_axis_tvalid};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NS; k++)
            begin
                if (ld[k])
                begin
                    v_reg[k] <= v_next[k];
                end
            end
        end
    end

    assign s_axis_tready = ld[0];
    assign m_axis_tvalid = v_reg[NS-1];

    // Stage 1: products.
    logic signed [CB-1:0] x_w, y_w;
    logic                 inv_w;
    assign x_w   = s_axis_tdata[CB-1:0];
    assign y_w   = s_axis_tdata[2*CB-1:CB];
    assign inv_w = (s_axis_tuser == FUNC_INVERSE);

    logic                       s1_inv_reg;
    logic signed [PW-1:0]       s1_pxx_reg, s1_pxy_reg, s1_pyx_reg, s1_pyy_reg;
    logic signed [2*MAT_W-1:0]  s1_t0_reg, s1_t1_reg, s1_t2_reg, s1_t3_reg;
    logic signed [2*MAT_W-1:0]  s1_d0_reg, s1_d1_reg;
    logic signed [PW-1:0]       s1_pxx_next, s1_pxy_next, s1_pyx_next, s1_pyy_next;
    logic signed [MAT_W-1:0]    cx_w, cy_w;

    assign cx_w        = inv_w ? m11_reg : m00_reg;
    assign cy_w        = inv_w ? m00_reg : m11_reg;
    assign s1_pxx_next = x_w * cx_w;
    assign s1_pxy_next = y_w * m10_reg;
    assign s1_pyx_next = x_w * m01_reg;
    assign s1_pyy_next = y_w * cy_w;

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            s1_inv_reg <= inv_w;
            s1_pxx_reg <= s1_pxx_next;
            s1_pxy_reg <= s1_pxy_next;
            s1_pyx_reg <= s1_pyx_next;
            s1_pyy_reg <= s1_pyy_next;
            s1_t0_reg  <= m20_reg * m11_reg;
            s1_t1_reg  <= m21_reg * m10_reg;
            s1_t2_reg  <= m21_reg * m00_reg;
            s1_t3_reg  <= m20_reg * m01_reg;
            s1_d0_reg  <= m00_reg * m11_reg;
            s1_d1_reg  <= m01_reg * m10_reg;
        end
    end

    // Stage 2: partial sums and determinant.
    logic                 s2_inv_reg;
    logic signed [AW-1:0] s2_ax_reg, s2_ay_reg, s2_ax_next, s2_ay_next;
    logic signed [DW-1:0] s2_bx_reg, s2_by_reg, s2_d_reg;
    logic signed [DW-1:0] s2_bx_next, s2_by_next, s2_d_next;

    assign s2_ax_next = s1_inv_reg ? (s1_pxx_reg - s1_pxy_reg) : (s1_pxx_reg + s1_pxy_reg);
    assign s2_ay_next = s1_inv_reg ? (s1_pyy_reg - s1_pyx_reg) : (s1_pyx_reg + s1_pyy_reg);
    assign s2_bx_next = s1_t0_reg - s1_t1_reg;
    assign s2_by_next = s1_t2_reg - s1_t3_reg;
    assign s2_d_next  = s1_d0_reg - s1_d1_reg;

    always_ff @(posedge clk)
    begin
        if (ld[1])
        begin
            s2_inv_reg <= s1_inv_reg;
            s2_ax_reg  <= s2_ax_next;
            s2_ay_reg  <= s2_ay_next;
            s2_bx_reg  <= s2_bx_next;
            s2_by_reg  <= s2_by_next;
            s2_d_reg   <= s2_d_next;
        end
    end

    // Stage 3: numerators and divisor. Forward work divides by 2^16.
    logic signed [NW-1:0] s3_n_reg [2];
    logic signed [NW-1:0] s3_n_next [2];
    logic signed [NW-1:0] ax_w, ay_w;
    logic signed [DW-1:0] s3_d_reg, s3_d_next;

    assign ax_w = s2_ax_reg;
    assign ay_w = s2_ay_reg;
    assign s3_n_next[0] = s2_inv_reg ? ((ax_w <<< FRAC_BITS) - s2_bx_reg) : (ax_w + m20_reg);
    assign s3_n_next[1] = s2_inv_reg ? ((ay_w <<< FRAC_BITS) - s2_by_reg) : (ay_w + m21_reg);
    assign s3_d_next    = s2_inv_reg ? s2_d_reg : D_FWD;

    always_ff @(posedge clk)
    begin
        if (ld[2])
        begin
            s3_n_reg[0] <= s3_n_next[0];
            s3_n_reg[1] <= s3_n_next[1];
            s3_d_reg    <= s3_d_next;
        end
    end

    // Stage 4: magnitudes and signs.
    logic [NW-1:0] s4_nm_reg [2];
    logic [NW-1:0] s4_nm_next [2];
    logic          s4_neg_reg [2];
    logic          s4_neg_next [2];
    logic [DW-1:0] s4_dm_reg, s4_dm_next;
    logic          s4_sing_reg, s4_sing_next;

    assign s4_dm_next   = s3_d_reg[DW-1] ? DW'(-s3_d_reg) : DW'(s3_d_reg);
    assign s4_sing_next = (s3_d_reg == '0);

    generate
        for (genvar l = 0; l < 2; l++)
        begin : g_abs
            assign s4_nm_next[l]  = s3_n_reg[l][NW-1] ? NW'(-s3_n_reg[l]) : NW'(s3_n_reg[l]);
            assign s4_neg_next[l] = s3_n_reg[l][NW-1] ^ s3_d_reg[DW-1];
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ld[3])
        begin
            s4_nm_reg[0] <= s4_nm_next[0];
            s4_nm_reg[1] <= s4_nm_next[1];
            s4_neg_reg[0] <= s4_neg_next[0];
            s4_neg_reg[1] <= s4_neg_next[1];
            s4_dm_reg   <= s4_dm_next;
            s4_sing_reg <= s4_sing_next;
        end
    end

    // Divider: entry 0 holds the overflow check, entry j the quotient bit CB+1-j.
    logic [RW-1:0]  dv_r_reg   [NDV][2];
    logic [CB:0]    dv_q_reg   [NDV][2];
    logic           dv_neg_reg [NDV][2];
    logic           dv_ovf_reg [NDV][2];
    logic [DW-1:0]  dv_dm_reg  [NDV];
    logic           dv_sing_reg [NDV];
    logic [RW-1:0]  dv_r_next  [NDV][2];
    logic [CB:0]    dv_q_next  [NDV][2];
    logic           dv_ovf_next [NDV][2];

    generate
        for (genvar l = 0; l < 2; l++)
        begin : g_ovf
            // A quotient of 2^(CB+1) or more saturates whatever the rounding.
            assign dv_ovf_next[0][l] = {{(RW-NW){1'b0}}, s4_nm_reg[l]}
                                       >= {s4_dm_reg, {(CB+1){1'b0}}};
            assign dv_r_next[0][l]   = RW'(s4_nm_reg[l]);
            assign dv_q_next[0][l]   = '0;
        end

        for (genvar j = 1; j < NDV; j++)
        begin : g_div
            for (genvar l = 0; l < 2; l++)
            begin : g_lane
                logic [RW-1:0] sh_w;
                logic          ge_w;
                assign sh_w = RW'(dv_dm_reg[j-1]) << (CB+1-j);
                assign ge_w = dv_r_reg[j-1][l] >= sh_w;
                assign dv_r_next[j][l]   = ge_w ? (dv_r_reg[j-1][l] - sh_w) : dv_r_reg[j-1][l];
                assign dv_q_next[j][l]   = dv_q_reg[j-1][l] | ((CB+1)'(ge_w) << (CB+1-j));
                assign dv_ovf_next[j][l] = dv_ovf_reg[j-1][l];
            end
        end
    endgenerate

    always_ff @(posedge clk)
    begin
        if (ld[DV0])
        begin
            for (int l = 0; l < 2; l++)
            begin
                dv_r_reg[0][l]   <= dv_r_next[0][l];
                dv_q_reg[0][l]   <= dv_q_next[0][l];
                dv_ovf_reg[0][l] <= dv_ovf_next[0][l];
                dv_neg_reg[0][l] <= s4_neg_reg[l];
            end
            dv_dm_reg[0]   <= s4_dm_reg;
            dv_sing_reg[0] <= s4_sing_reg;
        end
        for (int j = 1; j < NDV; j++)
        begin
            if (ld[DV0+j])
            begin
                for (int l = 0; l < 2; l++)
                begin
                    dv_r_reg[j][l]   <= dv_r_next[j][l];
                    dv_q_reg[j][l]   <= dv_q_next[j][l];
                    dv_ovf_reg[j][l] <= dv_ovf_next[j][l];
                    dv_neg_reg[j][l] <= dv_neg_reg[j-1][l];
                end
                dv_dm_reg[j]   <= dv_dm_reg[j-1];
                dv_sing_reg[j] <= dv_sing_reg[j-1];
            end
        end
    end

    // Output stage: round half away from zero, clamp, restore the sign.
    logic [CB-1:0] res_w [2];
    logic          sat_w [2];

    generate
        for (genvar l = 0; l < 2; l++)
        begin : g_rnd
            logic          up_w;
            logic [CB+1:0] qr_w, lim_w, mag_w, sgn_w;
            assign up_w  = {dv_r_reg[NDV-1][l][DW-1:0], 1'b0} >= {1'b0, dv_dm_reg[NDV-1]};
            assign qr_w  = (CB+2)'(dv_q_reg[NDV-1][l]) + (CB+2)'(up_w);
            assign lim_w = dv_neg_reg[NDV-1][l] ? LIM_NEG : LIM_POS;
            assign sat_w[l] = dv_ovf_reg[NDV-1][l] || (qr_w > lim_w);
            assign mag_w = sat_w[l] ? lim_w : qr_w;
            assign sgn_w = dv_neg_reg[NDV-1][l] ? (~mag_w + 1'b1) : mag_w;
            assign res_w[l] = sgn_w[CB-1:0];
        end
    endgenerate

    logic [CB-1:0] x_out_reg, y_out_reg, x_out_next, y_out_next;
    logic [1:0]    status_reg, status_next;

    always_comb
    begin
        if (dv_sing_reg[NDV-1])
        begin
            x_out_next  = '0;
            y_out_next  = '0;
            status_next = STATUS_SINGULAR;
        end
        else
        begin
            x_out_next  = res_w[0];
            y_out_next  = res_w[1];
            status_next = (sat_w[0] || sat_w[1]) ? STATUS_SAT : STATUS_OK;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[NS-1])
        begin
            x_out_reg  <= x_out_next;
            y_out_reg  <= y_out_next;
            status_reg <= status_next;
        end
    end

    assign m_axis_tdata = OUT_DW'({status_reg, y_out_reg, x_out_reg});

`ifndef SYNTH
    // An empty first stage must always be able to take a transaction.
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !v_reg[0] |-> s_axis_tready)
        else $error("input stalled with an empty first stage");

    a_accept_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> v_reg[0])
        else $error("accepted transaction lost at the first stage");

    // A saturated result has at least one coordinate on a bound.
    a_sat_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && status_reg == STATUS_SAT) |->
        (x_out_reg == LIM_POS[CB-1:0] || x_out_reg == LIM_NEG[CB-1:0] ||
         y_out_reg == LIM_POS[CB-1:0] || y_out_reg == LIM_NEG[CB-1:0]))
        else $error("saturated status without a clamped coordinate");

    a_sing_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && status_reg == STATUS_SINGULAR) |->
        (x_out_reg == '0 && y_out_reg == '0))
        else $error("singular result with nonzero coordinates");
`endif

endmodule

// ----- test/affine_point_transform_unit_checker.sv -----
// Checker of the affine point transform unit: predicts and compares every output transaction.
`timescale 1ns / 1ps
module affine_point_transform_unit_checker
    import apt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [MAT_W-1:0]      cfg_wdata,
    input  logic                  s_axis_tvalid,
    input  logic                  s_axis_tready,
    input  logic [31:0]           s_axis_tdata,
    input  logic                  s_axis_tuser,
    input  logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    input  logic [39:0]           m_axis_tdata,
    output int                    fail_count,
    output int                    points_pending,
    output int                    points_checked
);

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
        logic [1:0]  status;
    } point_result_t;

    logic signed [MAT_W-1:0] mat [6];
    point_result_t           expected_points [$];

    // Divides and rounds half away from zero, then clamps to 16-bit signed.
    function automatic void round_coord(input logic signed [127:0] num,
                                        input logic signed [127:0] den,
                                        output logic [15:0] val,
                                        output logic sat);
        logic [127:0] an;
        logic [127:0] ad;
        logic [127:0] q;
        logic [127:0] r;
        logic [127:0] lim;
        logic         neg;
        neg = num[127] ^ den[127];
        an  = num[127] ? -num : num;
        ad  = den[127] ? -den : den;
        q   = an / ad;
        r   = an % ad;
        if ((r << 1) >= ad)
            q = q + 1;
        lim = neg ? 128'd32768 : 128'd32767;
        sat = q > lim;
        if (sat)
            q = lim;
        val = neg ? -q[15:0] : q[15:0];
    endfunction

    function automatic point_result_t transform_point(input logic func,
                                                      input logic signed [15:0] x16,
                                                      input logic signed [15:0] y16);
        logic signed [127:0] xs;
        logic signed [127:0] ys;
        logic signed [127:0] a00;
        logic signed [127:0] a01;
        logic signed [127:0] a10;
        logic signed [127:0] a11;
        logic signed [127:0] a20;
        logic signed [127:0] a21;
        logic signed [127:0] det;
        logic signed [127:0] u;
        logic signed [127:0] v;
        logic                sx;
        logic                sy;
        point_result_t       res;
        xs  = x16;
        ys  = y16;
        a00 = mat[0];
        a01 = mat[1];
        a10 = mat[2];
        a11 = mat[3];
        a20 = mat[4];
        a21 = mat[5];
        res = '0;
        if (func != FUNC_INVERSE) begin
            round_coord(xs * a00 + ys * a10 + a20, 128'sd65536, res.x, sx);
            round_coord(xs * a01 + ys * a11 + a21, 128'sd65536, res.y, sy);
            res.status = (sx || sy) ? STATUS_SAT : STATUS_OK;
        end else begin
            det = a00 * a11 - a01 * a10;
            if (det == 0) begin
                res.status = STATUS_SINGULAR;
            end else begin
                u = xs * 128'sd65536 - a20;
                v = ys * 128'sd65536 - a21;
                round_coord(u * a11 - v * a10, det, res.x, sx);
                round_coord(v * a00 - u * a01, det, res.y, sy);
                res.status = (sx || sy) ? STATUS_SAT : STATUS_OK;
            end
        end
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        point_result_t want;
        point_result_t got;
        if (!rst_n) begin
            mat[0] <= UNITY;
            mat[1] <= '0;
            mat[2] <= '0;
            mat[3] <= UNITY;
            mat[4] <= '0;
            mat[5] <= '0;
            expected_points.delete();
            fail_count     <= 0;
            points_checked <= 0;
            points_pending <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_M00: mat[0] <= cfg_wdata;
                    REG_M01: mat[1] <= cfg_wdata;
                    REG_M10: mat[2] <= cfg_wdata;
                    REG_M11: mat[3] <= cfg_wdata;
                    REG_M20: mat[4] <= cfg_wdata;
                    REG_M21: mat[5] <= cfg_wdata;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_points.push_back(transform_point(s_axis_tuser,
                    s_axis_tdata[15:0], s_axis_tdata[31:16]));
            if (m_axis_tvalid && m_axis_tready) begin
                got = {m_axis_tdata[15:0], m_axis_tdata[31:16], m_axis_tdata[33:32]};
                points_checked <= points_checked + 1;
                if (expected_points.size() == 0) begin
                    $display("%0t: unexpected output transaction %h", $time, m_axis_tdata);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_points.pop_front();
                    if (want.x !== got.x || want.y !== got.y || want.status !== got.status) begin
                        $display("%0t: mismatch expected x=%h y=%h st=%0d, actual x=%h y=%h st=%0d",
                                 $time, want.x, want.y, want.status, got.x, got.y, got.status);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            points_pending <= expected_points.size();
        end
    end

endmodule

// ----- test/affine_point_transform_unit_tb.sv -----
// Top of the affine point transform unit testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module affine_point_transform_unit_tb;
    import apt_pkg::*;

    localparam logic [CFG_ADDR_W-1:0] REG_SPARE = 3'd6;
    localparam int IDLE_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 30;
    localparam int LONG_HOLD = 300;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_addr = '0;
    logic [31:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        s_axis_tuser = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;
    int          fail_count;
    int          points_pending;
    int          points_checked;
    int          idle_cycles = 0;
    int          points_sent = 0;
    int          matrices_loaded = 0;
    bit          no_gaps = 1'b0;
    bit          hold_request = 1'b0;
    logic [31:0] mat [6];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    affine_point_transform_unit DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata)
    );

    affine_point_transform_unit_checker checker_i (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .fail_count(fail_count), .points_pending(points_pending),
        .points_checked(points_checked)
    );

    function automatic int draw_gap();
        return no_gaps ? 0 : $urandom_range(0, 14);
    endfunction

    // Offers one point and holds it until the transaction completes.
    task automatic send_point(input logic func, input logic [15:0] x, input logic [15:0] y);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= {y, x};
        do @(posedge clk); while (!s_axis_tready);
        points_sent++;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lets the pipeline empty so that the matrix may be changed.
    task automatic drain_pipeline();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (points_pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // The spare index is written too; the block must ignore it.
    task automatic load_matrix();
        for (int i = 0; i < 7; i++) begin
            cfg_we    <= 1'b1;
            cfg_addr  <= (i == 6) ? REG_SPARE : CFG_ADDR_W'(REG_M00 + i);
            cfg_wdata <= (i == 6) ? $urandom : mat[i];
            @(posedge clk);
        end
        cfg_we <= 1'b0;
        matrices_loaded++;
    endtask

    task automatic set_matrix(input logic [31:0] a, b, c, d, e, f);
        mat[0] = a; mat[1] = b; mat[2] = c; mat[3] = d; mat[4] = e; mat[5] = f;
    endtask

    task automatic random_matrix(input int kind);
        logic [31:0] r;
        logic [31:0] s;
        r = $urandom;
        s = $urandom;
        case (kind)
            0: begin
                // Modest scale and shear, so that most results stay in range.
                for (int i = 0; i < 4; i++)
                    mat[i] = $signed($urandom_range(0, 262143)) - 131072;
                mat[4] = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
                mat[5] = $signed($urandom_range(0, 32'h0FFF_FFFF)) - 32'sh0800_0000;
            end
            1: for (int i = 0; i < 6; i++) mat[i] = $urandom;
            2: set_matrix(r, r, s, s, $urandom, $urandom);
            3: for (int i = 0; i < 6; i++) mat[i] = $urandom_range(0, 1) ? 32'h7FFF_FFFF
                                                                       : 32'h8000_0000;
            default: for (int i = 0; i < 6; i++)
                mat[i] = $signed($urandom_range(0, 131071)) - 65536;
        endcase
    endtask

    task automatic random_point();
        logic [15:0] x;
        logic [15:0] y;
        x = 16'($urandom);
        y = 16'($urandom);
        if ($urandom_range(0, 3) == 0) begin
            x = 16'($signed($urandom_range(0, 511)) - 256);
            y = 16'($signed($urandom_range(0, 511)) - 256);
        end
        send_point(1'($urandom_range(0, 1)), x, y);
    endtask

    always
    begin
        int gap;
        if (!rst_n) begin
            @(posedge clk);
        end else begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            gap = draw_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset matrix is the identity: coordinate extremes pass unchanged.
        send_point(1'b0, 16'h7FFF, 16'h8000);
        send_point(1'b0, 16'h8000, 16'h7FFF);
        send_point(1'b1, 16'hFFFF, 16'h0000);
        send_point(1'b1, 16'h7FFF, 16'h8000);
        drain_pipeline();

        // Half scale with a half-pixel offset: exact ties either side of zero.
        set_matrix(32'h0000_8000, 0, 0, 32'h0000_8000, 32'h0000_8000, 32'hFFFF_8000);
        load_matrix();
        send_point(1'b0, 16'd1, 16'd1);
        send_point(1'b0, 16'hFFFF, 16'hFFFF);
        send_point(1'b0, 16'hFFFE, 16'd2);
        send_point(1'b1, 16'd3, 16'hFFFD);
        send_point(1'b1, 16'h7FFF, 16'h8000);
        drain_pipeline();

        // Doubling: saturation in both directions.
        set_matrix(32'h0002_0000, 0, 0, 32'h0002_0000, 0, 0);
        load_matrix();
        send_point(1'b0, 16'h7FFF, 16'd5);
        send_point(1'b0, 16'h8000, 16'h8000);
        send_point(1'b1, 16'h8000, 16'h7FFF);
        drain_pipeline();

        // Zero matrix: inverse is singular, forward gives the translation, clamped to the coordinate range.
        set_matrix(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h8000_0000);
        load_matrix();
        send_point(1'b1, 16'd7, 16'd9);
        send_point(1'b0, 16'd7, 16'd9);
        drain_pipeline();

        // Register extremes.
        set_matrix(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                   32'h8000_0000, 32'h7FFF_FFFF);
        load_matrix();
        send_point(1'b0, 16'h7FFF, 16'h7FFF);
        send_point(1'b1, 16'h8000, 16'h0001);
        send_point(1'b1, 16'h0000, 16'h0000);
        drain_pipeline();

        for (int phase = 0; phase < 10; phase++) begin
            random_matrix(phase == 0 ? 0 : (phase % 5));
            load_matrix();
            no_gaps = (phase % 4 == 3);
            for (int n = 0; n < 125; n++) begin
                if (phase == 2 && n == 10)
                    hold_request = 1'b1;
                random_point();
            end
            no_gaps = 1'b0;
            drain_pipeline();
        end

        $display("Sent %0d points through %0d matrix settings; %0d results checked.",
                 points_sent, matrices_loaded, points_checked);
        $display("Covered forward and inverse, rounding ties, saturation and singular matrices.");
        if (fail_count == 0 && points_pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/apt_pkg.sv
hw/rtl/affine_point_transform_unit.sv
test/affine_point_transform_unit_checker.sv
test/affine_point_transform_unit_tb.sv
